FILE: hw/rtl/wsd_pkg.sv
// shared types, constants and field layout of the wheel sync drive controller
package wsd_pkg;

    // encoder position width
    localparam int POS_W = 24;

    // register widths
    localparam int TGT_W   = 24;
    localparam int PCT_W   = 7;
    localparam int TPS_W   = 16;
    localparam int TIME_W  = 24;
    localparam int CORR_W  = 15;
    localparam int DT_W    = 8;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    // output widths
    localparam int DRIVE_W = 16;
    localparam int CAUSE_W = 2;

    // correction gain 0.23 * 1800 * 256 = 207 << 9
    localparam int KP_MANT_W = 8;
    localparam logic [KP_MANT_W-1:0] KP_MANT = 8'd207;
    localparam int KP_SHIFT = 9;

    // serial divider sizing
    localparam int NUM_W  = POS_W + KP_MANT_W + KP_SHIFT;
    localparam int QUO_W  = 16;
    localparam int QCNT_W = $clog2(QUO_W);
    localparam int DS_W   = TGT_W + QUO_W - 1;
    localparam int CMP_W  = (NUM_W > DS_W + 1) ? NUM_W : DS_W + 1;

    // speed arithmetic, percent in q7.8
    localparam int SPD_W = 15;
    localparam int SUM_W = SPD_W + 3;
    localparam int MAG_W = SUM_W - 1;
    localparam logic [MAG_W-1:0] MIN_SPEED  = 17'd5120;
    localparam logic [MAG_W-1:0] FULL_SCALE = 17'd25600;
    localparam logic [TGT_W-1:0] DRIVE_DIV  = 24'd100;
    localparam int DRV_SHIFT = 8;
    localparam logic [QUO_W-1:0] DRIVE_MAX = 16'd32767;

    // run timing
    localparam logic [TIME_W-1:0] CONTACT_LIMIT_MS = 24'd3000;
    localparam logic [TIME_W-1:0] TIME_MAX         = 24'hFFFFFF;

    // register reset values
    localparam logic [TGT_W-1:0]  RST_TARGET   = 24'd1000;
    localparam logic [PCT_W-1:0]  RST_BASE_PCT = 7'd30;
    localparam logic [TPS_W-1:0]  RST_MAX_TPS  = 16'd4000;
    localparam logic [TIME_W-1:0] RST_TIMEOUT  = 24'd30000;
    localparam logic [CORR_W-1:0] RST_MAX_CORR = 15'd2176;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_PCT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_REV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_REV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TPS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TGT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CORR = 3'd7;

    // stop causes
    localparam logic [CAUSE_W-1:0] CAUSE_RUN     = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_TARGET  = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_CONTACT = 2'd3;

    // input tdata layout
    localparam int IN_LPOS_LO = 0;
    localparam int IN_RPOS_LO = POS_W;
    localparam int IN_LC_BIT  = 2 * POS_W;
    localparam int IN_RC_BIT  = 2 * POS_W + 1;
    localparam int IN_DT_LO   = 2 * POS_W + 2;
    localparam int IN_RST_BIT = IN_DT_LO + DT_W;
    localparam int IN_BITS    = IN_RST_BIT + 1;
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_BITS = 2 * DRIVE_W + 1 + CAUSE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic             restart;
        logic             left_contact;
        logic             right_contact;
        logic [DT_W-1:0]  elapsed_ms;
    } t_item_ctl;

    typedef struct packed {
        logic               drive_on;
        logic               finished;
        logic [CAUSE_W-1:0] cause;
    } t_run_dec;

    typedef struct packed {
        logic             neg;
        logic [SPD_W-1:0] mag;
    } t_speed;

    typedef struct packed {
        logic             done;
        logic             overflow;
        logic [QUO_W-1:0] quotient;
    } t_div_res;

endpackage

FILE: hw/rtl/wsd_serdiv.sv
// bit-serial restoring divider, one quotient bit per cycle with overflow flag
module wsd_serdiv (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [wsd_pkg::NUM_W-1:0]       i_dividend,
    input  logic [wsd_pkg::TGT_W-1:0]       i_divisor,
    output wsd_pkg::t_div_res               o_res,
    output logic                            o_busy
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;

    logic [1:0]                      r_state;
    logic [wsd_pkg::NUM_W-1:0]       r_rem;
    logic [wsd_pkg::DS_W-1:0]        r_ds;
    logic [wsd_pkg::QUO_W-1:0]       r_quo;
    logic [wsd_pkg::QCNT_W-1:0]      r_cnt;
    logic                            r_ovf;
    logic                            r_done;

    logic                            w_ge;
    logic [wsd_pkg::NUM_W-1:0]       w_diff;

    // trial subtract of the aligned divisor
    assign w_ge   = wsd_pkg::CMP_W'(r_rem) >= wsd_pkg::CMP_W'(r_ds);
    assign w_diff = wsd_pkg::NUM_W'(wsd_pkg::CMP_W'(r_rem) - wsd_pkg::CMP_W'(r_ds));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_CHK;
                    end
                end
                D_CHK: begin
                    r_state <= D_RUN;
                    r_cnt   <= '0;
                end
                D_RUN: begin
                    r_cnt <= r_cnt + wsd_pkg::QCNT_W'(1);
                    if (r_cnt == wsd_pkg::QCNT_W'(wsd_pkg::QUO_W - 1)) begin
                        r_state <= D_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_rem <= i_dividend;
            r_ds  <= {i_divisor, {(wsd_pkg::QUO_W - 1){1'b0}}};
            r_quo <= '0;
        end else if (r_state == D_CHK) begin
            // quotient needs more than QUO_W bits
            r_ovf <= wsd_pkg::CMP_W'(r_rem) >= wsd_pkg::CMP_W'({r_ds, 1'b0});
        end else if (r_state == D_RUN) begin
            if (w_ge) begin
                r_rem <= w_diff;
            end
            r_quo <= {r_quo[wsd_pkg::QUO_W-2:0], w_ge};
            r_ds  <= r_ds >> 1;
        end
    end

    assign o_res.done     = r_done;
    assign o_res.overflow = r_ovf;
    assign o_res.quotient = r_quo;
    assign o_busy         = (r_state != D_IDLE);

endmodule

FILE: hw/rtl/wsd_run_ctrl.sv
// run state: elapsed time, limit, contact flags and stop decision
module wsd_run_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_eval,
    input  wsd_pkg::t_item_ctl              i_item,
    input  logic [wsd_pkg::POS_W-1:0]       i_left_abs,
    input  logic [wsd_pkg::POS_W-1:0]       i_right_abs,
    input  logic [wsd_pkg::TGT_W-1:0]       i_target,
    input  logic                            i_stop_on_target,
    input  logic [wsd_pkg::TIME_W-1:0]      i_run_timeout,
    input  logic                            i_timeout_wr,
    input  logic [wsd_pkg::TIME_W-1:0]      i_timeout_data,
    output wsd_pkg::t_run_dec               o_dec
);

    localparam int TC_W = (wsd_pkg::POS_W > wsd_pkg::TGT_W) ? wsd_pkg::POS_W
                                                            : wsd_pkg::TGT_W;

    logic [wsd_pkg::TIME_W-1:0]  r_run_time;
    logic [wsd_pkg::TIME_W-1:0]  r_limit;
    logic                        r_lseen;
    logic                        r_rseen;
    logic                        r_over;
    logic [wsd_pkg::CAUSE_W-1:0] r_cause;

    logic [wsd_pkg::TIME_W-1:0]  n_run_time;
    logic [wsd_pkg::TIME_W-1:0]  n_limit;
    logic                        n_lseen;
    logic                        n_rseen;
    logic                        n_over;
    logic [wsd_pkg::CAUSE_W-1:0] n_cause;

    logic [wsd_pkg::TIME_W-1:0]  w_lim0;
    logic [wsd_pkg::TIME_W:0]    w_sum;
    logic [wsd_pkg::TIME_W-1:0]  w_tsat;
    logic                        w_tgt_hit;
    logic                        w_drive_on;

    always_comb begin
        // restart clears the run before the item is processed
        n_run_time = i_item.restart ? '0 : r_run_time;
        w_lim0     = i_item.restart ? i_run_timeout : r_limit;
        n_limit    = w_lim0;
        n_lseen    = i_item.restart ? 1'b0 : r_lseen;
        n_rseen    = i_item.restart ? 1'b0 : r_rseen;
        n_over     = i_item.restart ? 1'b0 : r_over;
        n_cause    = i_item.restart ? wsd_pkg::CAUSE_RUN : r_cause;
        w_drive_on = 1'b0;

        w_sum  = {1'b0, n_run_time} + (wsd_pkg::TIME_W + 1)'(i_item.elapsed_ms);
        w_tsat = w_sum[wsd_pkg::TIME_W] ? wsd_pkg::TIME_MAX : w_sum[wsd_pkg::TIME_W-1:0];
        w_tgt_hit = i_stop_on_target
                    && (TC_W'(i_left_abs) >= TC_W'(i_target))
                    && (TC_W'(i_right_abs) >= TC_W'(i_target));

        if (!n_over) begin
            n_run_time = w_tsat;
            if (w_tsat >= w_lim0) begin
                n_over  = 1'b1;
                n_cause = wsd_pkg::CAUSE_TIMEOUT;
            end else if (w_tgt_hit) begin
                n_over  = 1'b1;
                n_cause = wsd_pkg::CAUSE_TARGET;
            end else begin
                w_drive_on = 1'b1;
                // first closure of a contact restarts the clock on a short limit
                if (i_item.left_contact && !n_lseen) begin
                    n_lseen    = 1'b1;
                    n_run_time = '0;
                    n_limit    = wsd_pkg::CONTACT_LIMIT_MS;
                end
                if (i_item.right_contact && !n_rseen) begin
                    n_rseen    = 1'b1;
                    n_run_time = '0;
                    n_limit    = wsd_pkg::CONTACT_LIMIT_MS;
                end
                if (n_lseen && n_rseen) begin
                    n_over     = 1'b1;
                    n_cause    = wsd_pkg::CAUSE_CONTACT;
                    w_drive_on = 1'b0;
                end
            end
        end

        o_dec.drive_on = w_drive_on;
        o_dec.finished = n_over;
        o_dec.cause    = n_cause;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_time <= '0;
            r_limit    <= wsd_pkg::RST_TIMEOUT;
            r_lseen    <= 1'b0;
            r_rseen    <= 1'b0;
            r_over     <= 1'b0;
            r_cause    <= wsd_pkg::CAUSE_RUN;
        end else if (i_eval) begin
            r_run_time <= n_run_time;
            r_limit    <= n_limit;
            r_lseen    <= n_lseen;
            r_rseen    <= n_rseen;
            r_over     <= n_over;
            r_cause    <= n_cause;
        end else if (i_timeout_wr && !r_lseen && !r_rseen) begin
            r_limit <= i_timeout_data;
        end
    end

endmodule

FILE: hw/rtl/wsd_speed_shaper.sv
// applies the correction to both wheel speeds, minimum speed and full scale clamp
module wsd_speed_shaper (
    input  logic [wsd_pkg::CORR_W-1:0] i_corr_mag,
    input  logic                       i_corr_neg,
    input  logic [wsd_pkg::PCT_W-1:0]  i_base_pct,
    input  logic                       i_left_rev,
    input  logic                       i_right_rev,
    output wsd_pkg::t_speed            o_left,
    output wsd_pkg::t_speed            o_right
);

    logic w_delta_pos;

    function automatic wsd_pkg::t_speed shape(
        input logic                       rev,
        input logic                       delta_pos,
        input logic [wsd_pkg::CORR_W-1:0] cmag,
        input logic [wsd_pkg::PCT_W-1:0]  pct
    );
        logic signed [wsd_pkg::SUM_W-1:0] base;
        logic signed [wsd_pkg::SUM_W-1:0] delta;
        logic signed [wsd_pkg::SUM_W-1:0] s;
        logic [wsd_pkg::MAG_W-1:0]        a;
        wsd_pkg::t_speed                  res;
        base  = wsd_pkg::SUM_W'({pct, 8'b0});
        delta = wsd_pkg::SUM_W'(cmag);
        s = (rev ? -base : base) + (delta_pos ? delta : -delta);
        a = s[wsd_pkg::SUM_W-1] ? wsd_pkg::MAG_W'(-s) : wsd_pkg::MAG_W'(s);
        // small nonzero speeds are raised to the minimum
        if (a != '0 && a < wsd_pkg::MIN_SPEED) begin
            a = wsd_pkg::MIN_SPEED;
        end
        if (a > wsd_pkg::FULL_SCALE) begin
            a = wsd_pkg::FULL_SCALE;
        end
        res.neg = s[wsd_pkg::SUM_W-1];
        res.mag = a[wsd_pkg::SPD_W-1:0];
        return res;
    endfunction

    // the correction pushes both wheels the same way, direction by polarity
    assign w_delta_pos = i_corr_neg ? i_right_rev : i_left_rev;

    assign o_left  = shape(i_left_rev, w_delta_pos, i_corr_mag, i_base_pct);
    assign o_right = shape(i_right_rev, w_delta_pos, i_corr_mag, i_base_pct);

endmodule

FILE: hw/rtl/wheel_sync_drive_controller.sv
// top level of the wheel sync drive controller
//
// one input transaction is one control period of a straight two-wheel run and
// yields exactly one output transaction with both drive commands, the finished
// flag and the stop cause. a period that keeps the motors driven makes two
// passes through the bit-serial divider (16 quotient bits plus an overflow
// check each), first for the correction term against the target distance and
// then for both drive scalings by 100 side by side. a period that ends the
// run, or arrives after it ended, skips both divisions. the next transaction
// is taken while a result still waits in the output register. configuration
// is written through a plain write port; the user must write it only while
// the block is idle, the block itself does not enforce this.
module wheel_sync_drive_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // fields from bit 0: left_position, right_position, left_contact,
    // right_contact, elapsed_ms, restart, zero pad
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [wsd_pkg::IN_W-1:0]        s_axis_tdata,

    // fields from bit 0: left_drive, right_drive, finished, stop_cause, zero pad
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [wsd_pkg::OUT_W-1:0]       m_axis_tdata,

    input  logic                            i_cfg_we,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wsd_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_CDIV  = 3'd3;
    localparam logic [2:0] ST_SHAPE = 3'd4;
    localparam logic [2:0] ST_PROD  = 3'd5;
    localparam logic [2:0] ST_DDIV  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam int PROD_W = wsd_pkg::SPD_W + wsd_pkg::TPS_W;
    localparam int KPP_W  = wsd_pkg::POS_W + wsd_pkg::KP_MANT_W;

    // configuration registers
    logic [wsd_pkg::TGT_W-1:0]   r_target;
    logic [wsd_pkg::PCT_W-1:0]   r_base_pct;
    logic                        r_left_rev;
    logic                        r_right_rev;
    logic [wsd_pkg::TPS_W-1:0]   r_max_tps;
    logic [wsd_pkg::TIME_W-1:0]  r_timeout;
    logic                        r_stop_tgt;
    logic [wsd_pkg::CORR_W-1:0]  r_max_corr;

    // sequencer and item registers
    logic [2:0]                  r_state;
    logic [2:0]                  n_state;
    wsd_pkg::t_item_ctl          r_item;
    logic [wsd_pkg::POS_W-1:0]   r_left_abs;
    logic [wsd_pkg::POS_W-1:0]   r_right_abs;
    logic [wsd_pkg::POS_W-1:0]   r_diff_mag;
    logic                        r_diff_neg;
    logic [wsd_pkg::CORR_W-1:0]  r_corr_mag;
    wsd_pkg::t_speed             r_lspd;
    wsd_pkg::t_speed             r_rspd;
    logic                        r_fin;
    logic [wsd_pkg::CAUSE_W-1:0] r_cause;
    logic [wsd_pkg::DRIVE_W-1:0] r_left_drive;
    logic [wsd_pkg::DRIVE_W-1:0] r_right_drive;

    // output register
    logic                        r_out_valid;
    logic [wsd_pkg::OUT_W-1:0]   r_out_data;

    logic                        w_accept;
    logic                        w_out_load;
    logic [wsd_pkg::POS_W-1:0]   w_lpos;
    logic [wsd_pkg::POS_W-1:0]   w_rpos;
    wsd_pkg::t_run_dec           w_dec;
    logic                        w_timeout_wr;
    logic [KPP_W-1:0]            w_kp_prod;
    logic [wsd_pkg::NUM_W-1:0]   w_corr_num;
    logic [wsd_pkg::TGT_W-1:0]   w_tgt_div;
    logic [PROD_W-1:0]           w_lprod;
    logic [PROD_W-1:0]           w_rprod;
    logic                        w_div_a_start;
    logic                        w_div_b_start;
    logic [wsd_pkg::NUM_W-1:0]   w_div_a_num;
    logic [wsd_pkg::TGT_W-1:0]   w_div_a_den;
    wsd_pkg::t_div_res           w_div_a_res;
    wsd_pkg::t_div_res           w_div_b_res;
    logic                        w_div_a_busy;
    logic                        w_div_b_busy;
    wsd_pkg::t_speed             w_lshape;
    wsd_pkg::t_speed             w_rshape;

    function automatic logic [wsd_pkg::DRIVE_W-1:0] to_drive(
        input logic                      neg,
        input wsd_pkg::t_div_res         res
    );
        logic [wsd_pkg::DRIVE_W-1:0] mag;
        mag = (res.overflow || res.quotient > wsd_pkg::DRIVE_MAX)
              ? wsd_pkg::DRIVE_W'(wsd_pkg::DRIVE_MAX)
              : wsd_pkg::DRIVE_W'(res.quotient);
        return neg ? -mag : mag;
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    assign w_lpos = s_axis_tdata[wsd_pkg::IN_LPOS_LO +: wsd_pkg::POS_W];
    assign w_rpos = s_axis_tdata[wsd_pkg::IN_RPOS_LO +: wsd_pkg::POS_W];

    // ---------------- configuration port ----------------
    assign w_timeout_wr = i_cfg_we && (i_cfg_index == wsd_pkg::REG_TIMEOUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= wsd_pkg::RST_TARGET;
            r_base_pct  <= wsd_pkg::RST_BASE_PCT;
            r_left_rev  <= 1'b0;
            r_right_rev <= 1'b0;
            r_max_tps   <= wsd_pkg::RST_MAX_TPS;
            r_timeout   <= wsd_pkg::RST_TIMEOUT;
            r_stop_tgt  <= 1'b1;
            r_max_corr  <= wsd_pkg::RST_MAX_CORR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wsd_pkg::REG_TARGET:    r_target    <= i_cfg_data[wsd_pkg::TGT_W-1:0];
                wsd_pkg::REG_BASE_PCT:  r_base_pct  <= i_cfg_data[wsd_pkg::PCT_W-1:0];
                wsd_pkg::REG_LEFT_REV:  r_left_rev  <= i_cfg_data[0];
                wsd_pkg::REG_RIGHT_REV: r_right_rev <= i_cfg_data[0];
                wsd_pkg::REG_MAX_TPS:   r_max_tps   <= i_cfg_data[wsd_pkg::TPS_W-1:0];
                wsd_pkg::REG_TIMEOUT:   r_timeout   <= i_cfg_data[wsd_pkg::TIME_W-1:0];
                wsd_pkg::REG_STOP_TGT:  r_stop_tgt  <= i_cfg_data[0];
                wsd_pkg::REG_MAX_CORR:  r_max_corr  <= i_cfg_data[wsd_pkg::CORR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- run state and stop decision ----------------
    wsd_run_ctrl u_run_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_eval           (r_state == ST_EVAL),
        .i_item           (r_item),
        .i_left_abs       (r_left_abs),
        .i_right_abs      (r_right_abs),
        .i_target         (r_target),
        .i_stop_on_target (r_stop_tgt),
        .i_run_timeout    (r_timeout),
        .i_timeout_wr     (w_timeout_wr),
        .i_timeout_data   (i_cfg_data[wsd_pkg::TIME_W-1:0]),
        .o_dec            (w_dec)
    );

    // ---------------- serial dividers ----------------
    // correction numerator 105984 * |L - R|, a zero target divides by one
    assign w_kp_prod  = KPP_W'(r_diff_mag) * KPP_W'(wsd_pkg::KP_MANT);
    assign w_corr_num = {w_kp_prod, {wsd_pkg::KP_SHIFT{1'b0}}};
    assign w_tgt_div  = (r_target == '0) ? wsd_pkg::TGT_W'(1) : r_target;

    // speed magnitude times ticks/s, the q7.8 scale drops out by the shift
    assign w_lprod = PROD_W'(r_lspd.mag) * PROD_W'(r_max_tps);
    assign w_rprod = PROD_W'(r_rspd.mag) * PROD_W'(r_max_tps);

    // divider a: correction first, then the left drive; divider b: right drive
    assign w_div_a_start = (r_state == ST_MUL) || (r_state == ST_PROD);
    assign w_div_b_start = (r_state == ST_PROD);
    assign w_div_a_num   = (r_state == ST_MUL) ? w_corr_num
                           : wsd_pkg::NUM_W'(w_lprod[PROD_W-1:wsd_pkg::DRV_SHIFT]);
    assign w_div_a_den   = (r_state == ST_MUL) ? w_tgt_div : wsd_pkg::DRIVE_DIV;

    wsd_serdiv u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_a_start),
        .i_dividend (w_div_a_num),
        .i_divisor  (w_div_a_den),
        .o_res      (w_div_a_res),
        .o_busy     (w_div_a_busy)
    );

    wsd_serdiv u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_b_start),
        .i_dividend (wsd_pkg::NUM_W'(w_rprod[PROD_W-1:wsd_pkg::DRV_SHIFT])),
        .i_divisor  (wsd_pkg::DRIVE_DIV),
        .o_res      (w_div_b_res),
        .o_busy     (w_div_b_busy)
    );

    // ---------------- speed shaping ----------------
    wsd_speed_shaper u_shaper (
        .i_corr_mag  (r_corr_mag),
        .i_corr_neg  (r_diff_neg),
        .i_base_pct  (r_base_pct),
        .i_left_rev  (r_left_rev),
        .i_right_rev (r_right_rev),
        .o_left      (w_lshape),
        .o_right     (w_rshape)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_EVAL;
            ST_EVAL:  n_state = w_dec.drive_on ? ST_MUL : ST_OUT;
            ST_MUL:   n_state = ST_CDIV;
            ST_CDIV:  if (w_div_a_res.done) n_state = ST_SHAPE;
            ST_SHAPE: n_state = ST_PROD;
            ST_PROD:  n_state = ST_DDIV;
            ST_DDIV:  if (w_div_a_res.done) n_state = ST_OUT;
            ST_OUT:   if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.restart       <= s_axis_tdata[wsd_pkg::IN_RST_BIT];
            r_item.left_contact  <= s_axis_tdata[wsd_pkg::IN_LC_BIT];
            r_item.right_contact <= s_axis_tdata[wsd_pkg::IN_RC_BIT];
            r_item.elapsed_ms    <= s_axis_tdata[wsd_pkg::IN_DT_LO +: wsd_pkg::DT_W];
            r_left_abs  <= w_lpos[wsd_pkg::POS_W-1] ? -w_lpos : w_lpos;
            r_right_abs <= w_rpos[wsd_pkg::POS_W-1] ? -w_rpos : w_rpos;
        end
        if (r_state == ST_EVAL) begin
            r_fin      <= w_dec.finished;
            r_cause    <= w_dec.cause;
            r_diff_neg <= r_left_abs < r_right_abs;
            r_diff_mag <= (r_left_abs < r_right_abs) ? r_right_abs - r_left_abs
                                                     : r_left_abs - r_right_abs;
            if (!w_dec.drive_on) begin
                r_left_drive  <= '0;
                r_right_drive <= '0;
            end
        end
        // clamp the correction magnitude to the limit register
        if (r_state == ST_CDIV && w_div_a_res.done) begin
            r_corr_mag <= (w_div_a_res.overflow
                           || w_div_a_res.quotient > wsd_pkg::QUO_W'(r_max_corr))
                          ? r_max_corr : w_div_a_res.quotient[wsd_pkg::CORR_W-1:0];
        end
        if (r_state == ST_SHAPE) begin
            r_lspd <= w_lshape;
            r_rspd <= w_rshape;
        end
        if (r_state == ST_DDIV && w_div_a_res.done) begin
            r_left_drive  <= to_drive(r_lspd.neg, w_div_a_res);
            r_right_drive <= to_drive(r_rspd.neg, w_div_b_res);
        end
        if (w_out_load) begin
            r_out_data <= {(wsd_pkg::OUT_W - wsd_pkg::OUT_BITS)'(0),
                           r_cause, r_fin, r_right_drive, r_left_drive};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    // both drive dividers run in lockstep
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DDIV) |-> (w_div_a_busy == w_div_b_busy))
        else $error("drive dividers out of step");

    // finished goes with a nonzero stop cause
    a_fin_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[2*wsd_pkg::DRIVE_W]
            == (r_out_data[2*wsd_pkg::DRIVE_W+1 +: wsd_pkg::CAUSE_W] != wsd_pkg::CAUSE_RUN)))
        else $error("finished flag disagrees with stop cause");

    // a finished run never drives the motors
    a_fin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[2*wsd_pkg::DRIVE_W])
            |-> (r_out_data[2*wsd_pkg::DRIVE_W-1:0] == '0))
        else $error("nonzero drive after end of run");

endmodule
